### hdl/assert_macros.svh
// Assertion macros shared by the sorted priority queue modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every clock edge outside reset.
`define SPQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/spq_pkg.sv
// Types, codes and constants of the sorted priority queue.
package spq_pkg;

    localparam int SPQ_DEPTH = 8;

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    typedef enum logic [1:0] {
        STAT_ENQ = 2'd0,
        STAT_DEQ = 2'd1,
        STAT_OVF = 2'd2,
        STAT_UNF = 2'd3
    } spq_status_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } spq_state_t;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] value;
        logic        [7:0]  priority_req;
    } spq_in_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        spq_status_t        status;
        logic        [3:0]  occupancy;
    } spq_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic        load;
        logic        do_enq;
        logic        do_deq;
        logic        emit;
        spq_status_t res_code;
    } spq_ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_deq;
        logic full;
        logic empty;
    } spq_stat_t;

endpackage

### hdl/sorted_priority_queue.sv
// Top level of the sorted priority queue: controller plus datapath.
//
// Usage: a transaction is offered on item (cmd, value, priority_req) with
// start high; it is taken at the rising edge where start is high and busy
// is low. cmd enqueue inserts value behind every held entry whose priority
// number is equal or lower, so ties leave in arrival order; cmd dequeue
// removes the front entry, the one with the lowest priority number.
// Every transaction yields exactly one result on result, marked by done for
// one cycle: the dequeued word (zero otherwise), a status code (enqueued,
// dequeued, overflow on a full queue, underflow on an empty one) and the
// occupancy after the operation.
// Sequence: the accepting edge latches the request and enters execute; the
// edge that ends the execute state registers the result and raises done.
// A new transaction is not taken while busy is high during the execute
// state, in which the register array shifts and inserts in parallel.
// The result register sits apart from the array, so the next transaction is
// taken in the same cycle that the previous result is shown.
// Reset empties the queue; entry contents are left as they are and are never
// read before being written. The receiver cannot stall, so done is one cycle.

module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH = SPQ_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  spq_in_t  item,
    output logic     done,
    output spq_out_t result
);

    spq_ctl_t  ctl;
    spq_stat_t stat;

    // The controller sequences accept and execute; it sees only status flags.
    spq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .stat  (stat),
        .ctl   (ctl)
    );

    // The datapath holds the sorted entries and the result register.
    spq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .ctl    (ctl),
        .stat   (stat),
        .result (result)
    );

endmodule

### hdl/spq_ctrl.sv
// Controller state machine of the sorted priority queue.
`include "assert_macros.svh"

module spq_ctrl
    import spq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    output logic      done,
    input  spq_stat_t stat,
    output spq_ctl_t  ctl
);

    spq_state_t state_reg;
    spq_state_t state_next;
    logic       done_reg;
    logic       done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath commands.
    always_comb
    begin
        ctl       = '0;
        busy      = 1'b0;
        done_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                ctl.load = start;
            end
            ST_EXEC:
            begin
                busy      = 1'b1;
                done_next = 1'b1;
                ctl.emit  = 1'b1;
                if (stat.is_deq)
                begin
                    ctl.do_deq   = !stat.empty;
                    ctl.res_code = stat.empty ? STAT_UNF : STAT_DEQ;
                end
                else
                begin
                    ctl.do_enq   = !stat.full;
                    ctl.res_code = stat.full ? STAT_OVF : STAT_ENQ;
                end
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    assign done = done_reg;

    `SPQ_ASSERT_NEXT(a_exec_gives_done, state_reg == ST_EXEC, done_reg, "missing result strobe")
    `SPQ_ASSERT_NEXT(a_done_single, done_reg, !done_reg, "result strobe held too long")

endmodule

### hdl/spq_datapath.sv
// Sorted register array, request latch and result register of the queue.
`include "assert_macros.svh"

module spq_datapath
    import spq_pkg::*;
#(
    parameter int DEPTH = SPQ_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  spq_in_t   item,
    input  spq_ctl_t  ctl,
    output spq_stat_t stat,
    output spq_out_t  result
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    spq_in_t            req_reg;
    spq_out_t           res_reg;
    logic signed [31:0] data_reg [DEPTH];
    logic signed [31:0] data_next [DEPTH];
    logic        [7:0]  prio_reg [DEPTH];
    logic        [7:0]  prio_next [DEPTH];
    logic [DEPTH-1:0]   gt;
    logic [CNT_W+3:0]   occ_wide;

    // An entry moves back when it is valid and ranks behind the new one.
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            gt[i] = (CNT_W'(i) < count_reg) && (prio_reg[i] > req_reg.priority_req);
        end
    end

    always_comb
    begin
        logic [IDX_W-1:0] dn;
        logic [IDX_W-1:0] up;
        for (int i = 0; i < DEPTH; i++)
        begin
            dn = (i == 0) ? '0 : IDX_W'(i - 1);
            up = (i == DEPTH - 1) ? IDX_W'(i) : IDX_W'(i + 1);
            data_next[i] = data_reg[i];
            prio_next[i] = prio_reg[i];
            if (ctl.do_enq)
            begin
                if (i > 0 && gt[dn])
                begin
                    data_next[i] = data_reg[dn];
                    prio_next[i] = prio_reg[dn];
                end
                else if ((gt[i] || CNT_W'(i) == count_reg)
                         && (i == 0 || !gt[dn]))
                begin
                    data_next[i] = req_reg.value;
                    prio_next[i] = req_reg.priority_req;
                end
            end
            else if (ctl.do_deq)
            begin
                data_next[i] = data_reg[up];
                prio_next[i] = prio_reg[up];
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctl.do_enq)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctl.do_deq)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    assign occ_wide = {4'b0000, count_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            req_reg <= item;
        end
        if (ctl.emit)
        begin
            res_reg.result_value <= (ctl.res_code == STAT_DEQ) ? data_reg[0] : '0;
            res_reg.status       <= ctl.res_code;
            res_reg.occupancy    <= occ_wide[3:0];
        end
        for (int i = 0; i < DEPTH; i++)
        begin
            data_reg[i] <= data_next[i];
            prio_reg[i] <= prio_next[i];
        end
    end

    assign stat.is_deq = (req_reg.cmd == CMD_DEQ);
    assign stat.full   = (count_reg == CNT_W'(DEPTH));
    assign stat.empty  = (count_reg == '0);
    assign result      = res_reg;

    `SPQ_ASSERT(a_count_bound, count_reg <= CNT_W'(DEPTH), "occupancy above depth")
    `SPQ_ASSERT_NEXT(a_deq_shrinks, ctl.do_deq, count_reg == $past(count_reg - 1'b1), "bad dequeue count")

endmodule
